// ===== rtl/jac3d_pkg.sv =====
`timescale 1ns / 1ps

package jac3d_pkg;

  // Grid extents (storage is laid out for these, whatever sizes are in use)
  localparam int MAX_X = 32;
  localparam int MAX_Y = 32;
  localparam int MAX_Z = 32;

  localparam int CELL_W    = 32;
  localparam int COORD_W   = 5;
  localparam int SIZE_W    = 6;
  localparam int CFG_IDX_W = 2;
  localparam int OP_W      = 2;

  localparam int CELLS   = MAX_X * MAX_Y * MAX_Z;
  localparam int CELL_AW = $clog2(CELLS);
  localparam int MEM_AW  = CELL_AW + 1;
  localparam int PLANE   = MAX_X * MAX_Y;

  localparam logic [SIZE_W-1:0] LIM_X      = SIZE_W'(MAX_X);
  localparam logic [SIZE_W-1:0] LIM_Y      = SIZE_W'(MAX_Y);
  localparam logic [SIZE_W-1:0] LIM_Z      = SIZE_W'(MAX_Z);
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(32);

  // Seven-term sum and the digit-serial divide by seven
  localparam int STENCIL_PTS = 7;
  localparam int SUM_W       = CELL_W + $clog2(STENCIL_PTS);
  localparam int DIGIT_W     = 7;
  localparam int DIV_DIGITS  = (SUM_W + DIGIT_W - 1) / DIGIT_W;
  localparam int DIV_W       = DIV_DIGITS * DIGIT_W;
  localparam int DIV_CNT_W   = $clog2(DIV_DIGITS);
  localparam int REM_W       = 3;
  localparam int STEP_W      = REM_W + DIGIT_W;
  localparam int DIVISOR     = 7;
  localparam int DIV_BIAS    = 3;     // round to nearest: floor((|s| + 3) / 7)
  localparam int RECIP_7     = 1171;  // ceil(2^13 / 7), exact for STEP_W-bit values
  localparam int RECIP_SHIFT = 13;
  localparam int RECIP_W     = 11;
  localparam int PROD_W      = STEP_W + RECIP_W;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE   = 2'd0,
    OP_READ    = 2'd1,
    OP_COMPUTE = 2'd2,
    OP_SWAP    = 2'd3
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIZE_X = 2'd0,
    CFG_SIZE_Y = 2'd1,
    CFG_SIZE_Z = 2'd2
  } cfg_idx_t;

endpackage

// ===== rtl/jacobi_stencil_3d_periodic_unit.sv =====
`timescale 1ns / 1ps

// 7-point Jacobi stencil engine over two 3D grids with wrap-around boundaries.
// Command channel: start/busy. A command transfers at a clock edge with start
// high and busy low; fields are in_opcode, in_coord_x/y/z and in_cell_value.
// Opcodes: write a cell of the current grid, read it, compute one stencil cell
// into the other grid, or swap the two grids.
// Result channel: out_valid strobes for one cycle with out_result_value and
// out_status; the receiver always takes it and cannot stall the block.
// Config channel: cfg_valid/cfg_ready with cfg_index/cfg_data sets the grid
// sizes in use; cfg_ready is always high. Write sizes only while idle.
// A write, swap or bad coordinate strobes its result in the cycle after the
// accepting edge; a read waits in RDWAIT, a compute runs GATHER, DRAIN, PREP,
// DIV and STORE. A new command can transfer in the strobe cycle.
// A compute is bounded by the single grid memory port (seven neighbour reads,
// one write) and the divide by seven, which takes five 7-bit digits, one per
// cycle.
// Reset (synchronous, rst_n low) selects grid zero as current and sets all
// sizes to 32; grid contents are not cleared and must be written before use.
module jacobi_stencil_3d_periodic_unit
  import jac3d_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  // command channel
  input  logic                        start,
  output logic                        busy,
  input  logic [OP_W-1:0]             in_opcode,
  input  logic [COORD_W-1:0]          in_coord_x,
  input  logic [COORD_W-1:0]          in_coord_y,
  input  logic [COORD_W-1:0]          in_coord_z,
  input  logic signed [CELL_W-1:0]    in_cell_value,
  // result channel
  output logic                        out_valid,
  output logic signed [CELL_W-1:0]    out_result_value,
  output logic                        out_status,
  // configuration channel
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [SIZE_W-1:0]           cfg_data
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_RDWAIT = 7'b0000010,
    ST_GATHER = 7'b0000100,
    ST_DRAIN  = 7'b0001000,
    ST_PREP   = 7'b0010000,
    ST_DIV    = 7'b0100000,
    ST_STORE  = 7'b1000000
  } state_t;

  typedef enum logic [2:0] {
    TAP_C  = 3'd0,
    TAP_XM = 3'd1,
    TAP_XP = 3'd2,
    TAP_YM = 3'd3,
    TAP_YP = 3'd4,
    TAP_ZM = 3'd5,
    TAP_ZP = 3'd6
  } tap_t;

  // ---------------------------------------------------------------- helpers
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] r,
                                                 input logic [SIZE_W-1:0] lim);
    logic [SIZE_W-1:0] e;
    if (r == '0) begin
      e = SIZE_W'(1);
    end else if (r > lim) begin
      e = lim;
    end else begin
      e = r;
    end
    return e;
  endfunction

  function automatic logic [COORD_W-1:0] wrap_dec(input logic [COORD_W-1:0] c,
                                                  input logic [SIZE_W-1:0] n);
    logic [SIZE_W-1:0] nm1;
    nm1 = n - SIZE_W'(1);
    return (c == '0) ? nm1[COORD_W-1:0] : c - COORD_W'(1);
  endfunction

  function automatic logic [COORD_W-1:0] wrap_inc(input logic [COORD_W-1:0] c,
                                                  input logic [SIZE_W-1:0] n);
    logic [SIZE_W-1:0] c1;
    c1 = SIZE_W'(c) + SIZE_W'(1);
    return (c1 >= n) ? '0 : c1[COORD_W-1:0];
  endfunction

  function automatic logic [CELL_AW-1:0] cell_addr(input logic [COORD_W-1:0] x,
                                                   input logic [COORD_W-1:0] y,
                                                   input logic [COORD_W-1:0] z);
    return CELL_AW'(x) + CELL_AW'(y) * CELL_AW'(MAX_X) + CELL_AW'(z) * CELL_AW'(PLANE);
  endfunction

  // ---------------------------------------------------------------- state
  state_t                    state_r, state_nxt;
  tap_t                      tap_r, tap_nxt;
  logic                      cur_r, cur_nxt;
  logic                      rd_pend_r, rd_pend_nxt;
  logic [SIZE_W-1:0]         size_x_r, size_x_nxt;
  logic [SIZE_W-1:0]         size_y_r, size_y_nxt;
  logic [SIZE_W-1:0]         size_z_r, size_z_nxt;
  logic                      out_valid_r, out_valid_nxt;

  logic [CELL_W-1:0]         out_result_value_r, out_result_value_nxt;
  logic                      out_status_r, out_status_nxt;
  logic [COORD_W-1:0]        cx_r, cx_nxt, cy_r, cy_nxt, cz_r, cz_nxt;
  logic [SUM_W-1:0]          acc_r, acc_nxt;
  logic                      neg_r, neg_nxt;
  logic [DIV_W-1:0]          div_r, div_nxt;
  logic [DIV_W-1:0]          quo_r, quo_nxt;
  logic [REM_W-1:0]          rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0]      dcnt_r, dcnt_nxt;

  // grid memory: both grids, grid select in the top address bit
  logic [CELL_W-1:0]         mem [0:(2**MEM_AW)-1];
  logic [CELL_W-1:0]         rd_data_r;
  logic                      mem_we;
  logic [MEM_AW-1:0]         mem_addr;
  logic [CELL_W-1:0]         mem_wdata;

  // ---------------------------------------------------------------- decode
  logic [SIZE_W-1:0]         nx, ny, nz;
  logic                      accept;
  logic                      in_rng;
  opcode_t                   op_in;

  assign nx     = eff_size(size_x_r, LIM_X);
  assign ny     = eff_size(size_y_r, LIM_Y);
  assign nz     = eff_size(size_z_r, LIM_Z);
  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign op_in  = opcode_t'(in_opcode);
  assign in_rng = (SIZE_W'(in_coord_x) < nx) && (SIZE_W'(in_coord_y) < ny) &&
                  (SIZE_W'(in_coord_z) < nz);

  // neighbour address for the current tap
  logic [COORD_W-1:0]        tx, ty, tz;
  always_comb begin
    tx = cx_r;
    ty = cy_r;
    tz = cz_r;
    unique case (tap_r)
      TAP_C:   ;
      TAP_XM:  tx = wrap_dec(cx_r, nx);
      TAP_XP:  tx = wrap_inc(cx_r, nx);
      TAP_YM:  ty = wrap_dec(cy_r, ny);
      TAP_YP:  ty = wrap_inc(cy_r, ny);
      TAP_ZM:  tz = wrap_dec(cz_r, nz);
      TAP_ZP:  tz = wrap_inc(cz_r, nz);
      default: ;
    endcase
  end

  // one 7-bit digit of the divide by seven
  logic [STEP_W-1:0]         step_v;
  logic [PROD_W-1:0]         step_prod;
  logic [DIGIT_W-1:0]        step_q;
  logic [STEP_W-1:0]         step_back;
  logic [STEP_W-1:0]         step_rem;

  assign step_v    = {rem_r, div_r[DIV_W-1 -: DIGIT_W]};
  assign step_prod = PROD_W'(step_v) * PROD_W'(RECIP_7);
  assign step_q    = step_prod[RECIP_SHIFT +: DIGIT_W];
  assign step_back = STEP_W'(step_q) * STEP_W'(DIVISOR);
  assign step_rem  = step_v - step_back;

  // sum magnitude and rounded average
  logic [SUM_W-1:0]          acc_mag;
  logic [SUM_W-1:0]          rd_sext;
  logic [CELL_W-1:0]         avg;

  assign acc_mag = acc_r[SUM_W-1] ? (~acc_r + SUM_W'(1)) : acc_r;
  assign rd_sext = {{(SUM_W-CELL_W){rd_data_r[CELL_W-1]}}, rd_data_r};
  assign avg     = neg_r ? (~quo_r[CELL_W-1:0] + CELL_W'(1)) : quo_r[CELL_W-1:0];

  // ---------------------------------------------------------------- memory port
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = {cur_r, cell_addr(in_coord_x, in_coord_y, in_coord_z)};
    mem_wdata = in_cell_value;
    priority if (state_r == ST_STORE) begin
      mem_we    = 1'b1;
      mem_addr  = {~cur_r, cell_addr(cx_r, cy_r, cz_r)};
      mem_wdata = avg;
    end else if (state_r == ST_GATHER) begin
      mem_addr  = {cur_r, cell_addr(tx, ty, tz)};
    end else begin
      mem_we    = accept && (op_in == OP_WRITE) && in_rng;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_addr];
  end

  // ---------------------------------------------------------------- config
  assign cfg_ready = 1'b1;

  always_comb begin
    size_x_nxt = size_x_r;
    size_y_nxt = size_y_r;
    size_z_nxt = size_z_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SIZE_X: size_x_nxt = cfg_data;
        CFG_SIZE_Y: size_y_nxt = cfg_data;
        CFG_SIZE_Z: size_z_nxt = cfg_data;
        default:    ;
      endcase
    end
  end

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt            = state_r;
    tap_nxt              = tap_r;
    cur_nxt              = cur_r;
    rd_pend_nxt          = 1'b0;
    out_valid_nxt        = 1'b0;
    out_result_value_nxt = out_result_value_r;
    out_status_nxt       = out_status_r;
    cx_nxt               = cx_r;
    cy_nxt               = cy_r;
    cz_nxt               = cz_r;
    acc_nxt              = acc_r;
    neg_nxt              = neg_r;
    div_nxt              = div_r;
    quo_nxt              = quo_r;
    rem_nxt              = rem_r;
    dcnt_nxt             = dcnt_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cx_nxt               = in_coord_x;
          cy_nxt               = in_coord_y;
          cz_nxt               = in_coord_z;
          out_result_value_nxt = '0;
          out_status_nxt       = 1'b0;
          priority if (op_in == OP_SWAP) begin
            cur_nxt       = ~cur_r;
            out_valid_nxt = 1'b1;
          end else if (!in_rng) begin
            out_status_nxt = 1'b1;
            out_valid_nxt  = 1'b1;
          end else begin
            unique case (op_in)
              OP_READ:    state_nxt = ST_RDWAIT;
              OP_COMPUTE: begin
                state_nxt = ST_GATHER;
                tap_nxt   = TAP_C;
                acc_nxt   = '0;
              end
              default:    out_valid_nxt = 1'b1;  // write done by the memory port
            endcase
          end
        end
      end

      ST_RDWAIT: begin
        out_result_value_nxt = rd_data_r;
        out_valid_nxt        = 1'b1;
        state_nxt            = ST_IDLE;
      end

      // one neighbour read a cycle, summing the data of the previous read
      ST_GATHER: begin
        rd_pend_nxt = 1'b1;
        if (rd_pend_r) begin
          acc_nxt = acc_r + rd_sext;
        end
        if (tap_r == TAP_ZP) begin
          state_nxt = ST_DRAIN;
        end else begin
          tap_nxt = tap_t'(tap_r + 3'd1);
        end
      end

      ST_DRAIN: begin
        acc_nxt   = acc_r + rd_sext;
        state_nxt = ST_PREP;
      end

      ST_PREP: begin
        neg_nxt   = acc_r[SUM_W-1];
        div_nxt   = DIV_W'(acc_mag) + DIV_W'(DIV_BIAS);
        quo_nxt   = '0;
        rem_nxt   = '0;
        dcnt_nxt  = '0;
        state_nxt = ST_DIV;
      end

      // long division by seven, most significant digit first
      ST_DIV: begin
        div_nxt = div_r << DIGIT_W;
        quo_nxt = {quo_r[DIV_W-DIGIT_W-1:0], step_q};
        rem_nxt = step_rem[REM_W-1:0];
        if (dcnt_r == DIV_CNT_W'(DIV_DIGITS - 1)) begin
          state_nxt = ST_STORE;
        end else begin
          dcnt_nxt = dcnt_r + DIV_CNT_W'(1);
        end
      end

      ST_STORE: begin
        out_result_value_nxt = avg;
        out_valid_nxt        = 1'b1;
        state_nxt            = ST_IDLE;
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tap_r       <= TAP_C;
      cur_r       <= 1'b0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
      size_x_r    <= SIZE_RESET;
      size_y_r    <= SIZE_RESET;
      size_z_r    <= SIZE_RESET;
    end else begin
      state_r     <= state_nxt;
      tap_r       <= tap_nxt;
      cur_r       <= cur_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
      size_x_r    <= size_x_nxt;
      size_y_r    <= size_y_nxt;
      size_z_r    <= size_z_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    out_result_value_r <= out_result_value_nxt;
    out_status_r       <= out_status_nxt;
    cx_r               <= cx_nxt;
    cy_r               <= cy_nxt;
    cz_r               <= cz_nxt;
    acc_r              <= acc_nxt;
    neg_r              <= neg_nxt;
    div_r              <= div_nxt;
    quo_r              <= quo_nxt;
    rem_r              <= rem_nxt;
    dcnt_r             <= dcnt_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_result_value_r;
  assign out_status       = out_status_r;

`ifndef SYNTHESIS
  // a result only appears once the sequencer is back at rest
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == ST_IDLE))
    else $error("result strobe while sequencer busy");

  // swap answers next cycle with a zero, ok result
  a_swap_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (op_in == OP_SWAP)) |=>
      (out_valid_r && !out_status_r && (out_result_value_r == '0)))
    else $error("swap result missing or wrong");

  // grid roles change only on a swap transfer
  a_grid_sel: assert property (@(posedge clk) disable iff (!rst_n)
    !(accept && (op_in == OP_SWAP)) |=> $stable(cur_r))
    else $error("grid select changed without swap");

  // bad coordinate flags status next cycle
  a_oob_status: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (op_in != OP_SWAP) && !in_rng) |=> (out_valid_r && out_status_r))
    else $error("out-of-range command not flagged");

  // memory writes only from a write command or the stencil store
  a_mem_write: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> ((state_r == ST_STORE) || (accept && (op_in == OP_WRITE))))
    else $error("unexpected grid memory write");
`endif

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import jac3d_pkg::*;

  localparam int ITEM_TARGET = 1700;
  localparam int STALL_LIMIT = 2000;
  localparam int REGION_CAP  = 64;    // cells per phase region, keeps sweeps short
  localparam int IDLE_PCT    = 29;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;  // index with no register
  localparam logic [CELL_W-1:0] FULL_POS = 32'h7FFF_FFFF;
  localparam logic [CELL_W-1:0] FULL_NEG = 32'h8000_0000;

  typedef struct packed {
    opcode_t              op;
    logic [COORD_W-1:0]   x;
    logic [COORD_W-1:0]   y;
    logic [COORD_W-1:0]   z;
    logic [CELL_W-1:0]    value;
  } grid_cmd_t;

  typedef struct packed {
    logic [CELL_W-1:0] value;
    logic              status;
  } grid_reply_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        start = 1'b0;
  logic                        busy;
  logic [OP_W-1:0]             in_opcode = '0;
  logic [COORD_W-1:0]          in_coord_x = '0;
  logic [COORD_W-1:0]          in_coord_y = '0;
  logic [COORD_W-1:0]          in_coord_z = '0;
  logic signed [CELL_W-1:0]    in_cell_value = '0;
  logic                        out_valid;
  logic signed [CELL_W-1:0]    out_result_value;
  logic                        out_status;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [CFG_IDX_W-1:0]        cfg_index = '0;
  logic [SIZE_W-1:0]           cfg_data = '0;

  jacobi_stencil_3d_periodic_unit uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_opcode        (in_opcode),
    .in_coord_x       (in_coord_x),
    .in_coord_y       (in_coord_y),
    .in_coord_z       (in_coord_z),
    .in_cell_value    (in_cell_value),
    .out_valid        (out_valid),
    .out_result_value (out_result_value),
    .out_status       (out_status),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  grid_cmd_t   cmd_backlog[$];
  grid_reply_t expected_replies[$];
  int          mismatch_count = 0;

  // Shadow of the block: both grids, which one is current, size registers
  logic [CELL_W-1:0] shadow_grid [2][CELLS];
  bit                shadow_cur;
  logic [SIZE_W-1:0] shadow_size [3];

  // Stimulus side bookkeeping: which cells hold a written value
  bit                cell_filled [2][CELLS];
  bit                gen_cur = 1'b0;
  int unsigned       gen_n [3] = '{32, 32, 32};
  int                items_made = 0;

  // ---------------------------------------------------------------------------
  // Grid geometry shared by the predictor and the stimulus
  function automatic int unsigned eff_size(input logic [SIZE_W-1:0] r, input int maxv);
    if (r < 1) return 1;
    if (r > maxv) return maxv;
    return r;
  endfunction

  function automatic int unsigned cell_addr(input int unsigned x, y, z);
    return x + y * MAX_X + z * PLANE;
  endfunction

  function automatic int unsigned wrap_dn(input int unsigned c, n);
    return (c == 0) ? n - 1 : c - 1;
  endfunction

  function automatic int unsigned wrap_up(input int unsigned c, n);
    return (c + 1 >= n) ? 0 : c + 1;
  endfunction

  // k-th point of the 7-point stencil around (x,y,z)
  function automatic int unsigned stencil_addr(input int unsigned x, y, z, k, nx, ny, nz);
    case (k)
      0:       return cell_addr(x, y, wrap_dn(z, nz));
      1:       return cell_addr(x, wrap_dn(y, ny), z);
      2:       return cell_addr(wrap_dn(x, nx), y, z);
      4:       return cell_addr(wrap_up(x, nx), y, z);
      5:       return cell_addr(x, wrap_up(y, ny), z);
      6:       return cell_addr(x, y, wrap_up(z, nz));
      default: return cell_addr(x, y, z);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Predictor: applies one command to the shadow grids, returns the reply
  function automatic grid_reply_t apply_grid_op(input grid_cmd_t c);
    grid_reply_t r;
    int unsigned nx, ny, nz, a;
    longint      acc, mag, q, rounded;
    r.value  = '0;
    r.status = 1'b0;
    nx = eff_size(shadow_size[0], MAX_X);
    ny = eff_size(shadow_size[1], MAX_Y);
    nz = eff_size(shadow_size[2], MAX_Z);
    a  = cell_addr(c.x, c.y, c.z);
    if (c.op == OP_SWAP) begin
      shadow_cur = !shadow_cur;
    end else if (c.x >= nx || c.y >= ny || c.z >= nz) begin
      r.status = 1'b1;
    end else begin
      case (c.op)
        OP_WRITE: shadow_grid[shadow_cur][a] = c.value;
        OP_READ:  r.value = shadow_grid[shadow_cur][a];
        default: begin
          acc = 0;
          for (int k = 0; k < STENCIL_PTS; k++)
            acc += longint'($signed(shadow_grid[shadow_cur][stencil_addr(c.x, c.y, c.z,
                                                                          k, nx, ny, nz)]));
          // divide by seven, round half away from zero
          mag     = (acc < 0) ? -acc : acc;
          q       = (2 * mag + 7) / 14;
          rounded = (acc < 0) ? -q : q;
          r.value = rounded[CELL_W-1:0];
          shadow_grid[!shadow_cur][a] = r.value;
        end
      endcase
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  function automatic logic [CELL_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return FULL_POS;
      1:       return FULL_NEG;
      2:       return CELL_W'(int'($urandom_range(0, 15)) - 8);
      3:       return '0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return SIZE_W'(1);
      2:       return SIZE_W'(32);
      3:       return SIZE_W'($urandom_range(33, 63));
      default: return SIZE_W'($urandom_range(2, 8));
    endcase
  endfunction

  // never let a read or compute touch a cell that holds no written value
  function automatic bit cmd_legal(input opcode_t op, input int unsigned x, y, z);
    if (op == OP_SWAP || op == OP_WRITE) return 1'b1;
    if (x >= gen_n[0] || y >= gen_n[1] || z >= gen_n[2]) return 1'b1;
    if (op == OP_READ) return cell_filled[gen_cur][cell_addr(x, y, z)];
    for (int k = 0; k < STENCIL_PTS; k++)
      if (!cell_filled[gen_cur][stencil_addr(x, y, z, k, gen_n[0], gen_n[1], gen_n[2])])
        return 1'b0;
    return 1'b1;
  endfunction

  task automatic queue_cmd(input opcode_t op, input int unsigned x, y, z,
                           input logic [CELL_W-1:0] v);
    grid_cmd_t c;
    c.op    = op;
    c.x     = COORD_W'(x);
    c.y     = COORD_W'(y);
    c.z     = COORD_W'(z);
    c.value = v;
    cmd_backlog.push_back(c);
    items_made++;
    if (op == OP_SWAP) begin
      gen_cur = !gen_cur;
    end else if (x < gen_n[0] && y < gen_n[1] && z < gen_n[2]) begin
      if (op == OP_WRITE) cell_filled[gen_cur][cell_addr(x, y, z)] = 1'b1;
      else if (op == OP_COMPUTE) cell_filled[!gen_cur][cell_addr(x, y, z)] = 1'b1;
    end
  endtask

  // stray write, read or compute, now and then outside the region in use
  task automatic queue_noise();
    opcode_t     op;
    int unsigned x, y, z;
    op = opcode_t'($urandom_range(0, 2));
    if ($urandom_range(0, 4) == 0) begin
      x = $urandom_range(0, 31);
      y = $urandom_range(0, 31);
      z = $urandom_range(0, 31);
    end else begin
      x = $urandom_range(0, gen_n[0] - 1);
      y = $urandom_range(0, gen_n[1] - 1);
      z = $urandom_range(0, gen_n[2] - 1);
    end
    if (!cmd_legal(op, x, y, z)) op = OP_WRITE;
    queue_cmd(op, x, y, z, pick_value());
  endtask

  // fill the region, then one to three full sweeps each closed by a swap
  task automatic queue_phase();
    int unsigned sweeps;
    sweeps = $urandom_range(1, 3);
    for (int z = 0; z < gen_n[2]; z++)
      for (int y = 0; y < gen_n[1]; y++)
        for (int x = 0; x < gen_n[0]; x++)
          if (!cell_filled[gen_cur][cell_addr(x, y, z)] || $urandom_range(0, 3) == 0)
            queue_cmd(OP_WRITE, x, y, z, pick_value());
    repeat (sweeps) begin
      for (int z = 0; z < gen_n[2]; z++)
        for (int y = 0; y < gen_n[1]; y++)
          for (int x = 0; x < gen_n[0]; x++) begin
            if ($urandom_range(0, 9) < 3) queue_noise();
            queue_cmd(OP_COMPUTE, x, y, z, $urandom);
          end
      queue_cmd(OP_SWAP, $urandom_range(0, 31), $urandom_range(0, 31),
                $urandom_range(0, 31), $urandom);
    end
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // checked away from the rising edge so the driver's pending start is seen,
  // then realigned to the rising edge for the next drive
  task automatic wait_drained();
    do @(negedge clk);
    while (cmd_backlog.size() != 0 || start || expected_replies.size() != 0);
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Command driver
  always @(posedge clk) begin : drive_proc
    grid_cmd_t nxt;
    int        launched;
    bit        calm;
    if (!rst_n) begin
      start    <= 1'b0;
      launched = 0;
    end else if (!start || !busy) begin
      calm = (launched >= 400 && launched < 700);
      if (cmd_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
        nxt = cmd_backlog.pop_front();
        start         <= 1'b1;
        in_opcode     <= nxt.op;
        in_coord_x    <= nxt.x;
        in_coord_y    <= nxt.y;
        in_coord_z    <= nxt.z;
        in_cell_value <= nxt.value;
        launched++;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: size register writes, reply check, prediction on each transfer
  always @(posedge clk) begin : check_proc
    grid_cmd_t   seen;
    grid_reply_t want;
    if (!rst_n) begin
      shadow_cur  = 1'b0;
      shadow_size = '{SIZE_RESET, SIZE_RESET, SIZE_RESET};
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SIZE_X: shadow_size[0] = cfg_data;
          CFG_SIZE_Y: shadow_size[1] = cfg_data;
          CFG_SIZE_Z: shadow_size[2] = cfg_data;
          default: ;
        endcase
      end
      if (out_valid) begin
        if (expected_replies.size() == 0) begin
          mismatch_count++;
          $display("%0t: reply with none outstanding, expected nothing, actual value %h status %b",
                   $time, out_result_value, out_status);
        end else begin
          want = expected_replies.pop_front();
          if (out_result_value !== want.value) begin
            mismatch_count++;
            $display("%0t: result_value expected %h actual %h",
                     $time, want.value, out_result_value);
          end
          if (out_status !== want.status) begin
            mismatch_count++;
            $display("%0t: status expected %b actual %b", $time, want.status, out_status);
          end
        end
      end
      if (start && !busy) begin
        seen.op    = opcode_t'(in_opcode);
        seen.x     = in_coord_x;
        seen.y     = in_coord_y;
        seen.z     = in_coord_z;
        seen.value = in_cell_value;
        expected_replies.push_back(apply_grid_op(seen));
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin : watchdog_proc
    int stall_cycles;
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed commands at reset sizes, then random phases
  initial begin : sequence_proc
    logic [SIZE_W-1:0] raw [3];
    logic [SIZE_W-1:0] preset [3][3];
    int                phase;
    preset = '{'{6'd0, 6'd63, 6'd1}, '{6'd32, 6'd1, 6'd0}, '{6'd1, 6'd0, 6'd33}};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // full scale centre and neighbours, wrapping on every axis at size 32
    queue_cmd(OP_WRITE, 0, 0, 0, FULL_POS);
    queue_cmd(OP_WRITE, 31, 0, 0, FULL_POS);
    queue_cmd(OP_WRITE, 1, 0, 0, FULL_POS);
    queue_cmd(OP_WRITE, 0, 31, 0, FULL_POS);
    queue_cmd(OP_WRITE, 0, 1, 0, FULL_POS);
    queue_cmd(OP_WRITE, 0, 0, 31, FULL_POS);
    queue_cmd(OP_WRITE, 0, 0, 1, FULL_POS);
    queue_cmd(OP_COMPUTE, 0, 0, 0, $urandom);
    queue_cmd(OP_WRITE, 0, 0, 0, FULL_NEG);
    queue_cmd(OP_COMPUTE, 0, 0, 0, $urandom);
    queue_cmd(OP_WRITE, 31, 0, 0, '0);
    queue_cmd(OP_COMPUTE, 0, 0, 0, $urandom);
    queue_cmd(OP_READ, 0, 0, 0, $urandom);
    queue_cmd(OP_WRITE, 31, 31, 31, '1);
    queue_cmd(OP_READ, 31, 31, 31, $urandom);
    // swap ignores its coordinates and value
    queue_cmd(OP_SWAP, 31, 31, 31, FULL_NEG);
    queue_cmd(OP_READ, 0, 0, 0, $urandom);
    queue_cmd(OP_SWAP, 0, 0, 0, '0);
    queue_cmd(OP_READ, 0, 0, 1, $urandom);

    phase = 0;
    while (items_made < ITEM_TARGET) begin
      wait_drained();
      if (phase < 3) begin
        raw = preset[phase];
      end else begin
        do begin
          foreach (raw[i]) raw[i] = pick_size();
        end while (eff_size(raw[0], MAX_X) * eff_size(raw[1], MAX_Y) *
                   eff_size(raw[2], MAX_Z) > REGION_CAP);
      end
      cfg_write(CFG_SIZE_X, raw[0]);
      cfg_write(CFG_SIZE_Y, raw[1]);
      cfg_write(CFG_SIZE_Z, raw[2]);
      // a write to the spare index must leave all sizes alone
      if (phase == 0 || $urandom_range(0, 3) == 0)
        cfg_write(CFG_UNUSED, SIZE_W'($urandom));
      cfg_valid <= 1'b0;
      gen_n[0] = eff_size(raw[0], MAX_X);
      gen_n[1] = eff_size(raw[1], MAX_Y);
      gen_n[2] = eff_size(raw[2], MAX_Z);
      queue_phase();
      phase++;
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
